>>> design/stt_pkg.sv
// ----------------------------------------------------------------------------
// Sensor tag table package
// Shared sizes, operation and action codes, and the beat and compare types.
// ----------------------------------------------------------------------------
package stt_pkg;

	// Table depth and the widths that follow from it.
	localparam int TABLE_ENTRIES = 8;
	localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

	localparam int MAC_W   = 48;
	localparam int TIME_W  = 32;
	localparam int RDG_W   = 64;
	localparam int FLAG_W  = 8;
	localparam int INDEX_W = 6;
	localparam int COUNT_W = 7;

	localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd60000;

	// Operation codes of a request beat.
	localparam logic [1:0] OP_SIGHT = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// Action codes of a response beat.
	localparam logic [2:0] ACT_UPDATED  = 3'd0;
	localparam logic [2:0] ACT_APPENDED = 3'd1;
	localparam logic [2:0] ACT_EVICTED  = 3'd2;
	localparam logic [2:0] ACT_READ_OK  = 3'd3;
	localparam logic [2:0] ACT_READ_OOR = 3'd4;
	localparam logic [2:0] ACT_CLEARED  = 3'd5;

	typedef struct packed {
		logic [1:0]        operation;
		logic [MAC_W-1:0]  mac;
		logic signed [15:0] temp_centi;
		logic [15:0]       humid_centi;
		logic [15:0]       batt_millivolts;
		logic [7:0]        batt_percent;
		logic [7:0]        frame_counter;
		logic [7:0]        tag_flags;
		logic [TIME_W-1:0] now_ms;
		logic [INDEX_W-1:0] index;
	} stt_req_t;

	typedef struct packed {
		logic [2:0]         action;
		logic [INDEX_W-1:0] slot;
		logic [MAC_W-1:0]   entry_mac;
		logic signed [15:0] entry_temp;
		logic [15:0]        entry_humid;
		logic [15:0]        entry_batt_mv;
		logic [7:0]         entry_batt_pct;
		logic [7:0]         entry_counter;
		logic [7:0]         entry_flags;
		logic               entry_active;
		logic [COUNT_W-1:0] tag_count;
		logic [COUNT_W-1:0] active_count;
	} stt_rsp_t;

	// Verdict of the shared compare unit on one stored entry.
	typedef struct packed {
		logic              match;
		logic              active;
		logic              older;
		logic [TIME_W-1:0] age;
	} stt_cmp_t;

endpackage

>>> design/stt_cmp.sv
// ----------------------------------------------------------------------------
// Sensor tag table entry compare unit
// Judges one stored entry per cycle: key match, wrapping age, activity and
// whether it is older than the oldest entry seen so far.
// ----------------------------------------------------------------------------
module stt_cmp
	import stt_pkg::*;
(
	input  logic [MAC_W-1:0]  key,
	input  logic [TIME_W-1:0] stamp,
	input  logic [MAC_W-1:0]  mac,
	input  logic [TIME_W-1:0] now_ms,
	input  logic [TIME_W-1:0] timeout,
	input  logic [TIME_W-1:0] best_age,
	output stt_cmp_t          verdict
);

	logic [TIME_W-1:0] age;

	// The subtraction wraps modulo 2^32, as the time base does.
	assign age = now_ms - stamp;

	always_comb begin
		verdict.match  = (key == mac);
		verdict.age    = age;
		verdict.active = (age <= timeout);
		verdict.older  = (age > best_age);
	end

endmodule

>>> design/sensor_tag_table.sv
// ----------------------------------------------------------------------------
// Sensor tag table
// Associative table of sensor tags keyed by MAC, with replacement of the
// oldest entry when full, indexed reads and an active-tag count.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake           Payload
//  -------  ---------  ------------------  ----------------------------------
//  req      in         req_valid/req_ready stt_req_t: operation, sighting data
//  rsp      out        rsp_valid/rsp_ready stt_rsp_t: action, slot, entry, counts
//  cfg      in         cfg_we              cfg_wdata: active timeout in ms
//
// A request beat is accepted in idle, then takes one scan step per entry through the single
// read port and the shared compare unit, one step to drain the read register and a final
// step that writes a sighting and registers the response, which an OP_NONE beat does not
// raise. A new request is accepted in idle even while the previous response waits; the
// final step stalls only while the response register is still full. Reset empties the
// table and loads 60000 ms.
//
module sensor_tag_table
	import stt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  stt_req_t    req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output stt_rsp_t    rsp,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	// Sequencer states.
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam logic [IDX_W-1:0] LAST_PTR = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

	logic [1:0]        state_q;
	logic [IDX_W-1:0]  ptr_q;
	stt_req_t          req_q;
	logic [TIME_W-1:0] timeout_q;
	logic [CNT_W-1:0]  count_q;

	// Entry store: one row per table entry, read one row per cycle.
	logic [MAC_W-1:0]  key_mem   [TABLE_ENTRIES];
	logic [RDG_W-1:0]  rdg_mem   [TABLE_ENTRIES];
	logic [FLAG_W-1:0] flag_mem  [TABLE_ENTRIES];
	logic [TIME_W-1:0] stamp_mem [TABLE_ENTRIES];

	// Registered read of the row under the scan pointer.
	logic              pipe_vld_s1;
	logic [IDX_W-1:0]  pipe_k_s1;
	logic [MAC_W-1:0]  key_s1;
	logic [RDG_W-1:0]  rdg_s1;
	logic [FLAG_W-1:0] flag_s1;
	logic [TIME_W-1:0] stamp_s1;

	// Scan results.
	logic              found_q;
	logic [IDX_W-1:0]  hit_q;
	logic              hit_act_q;
	logic [CNT_W-1:0]  act_cnt_q;
	logic [TIME_W-1:0] best_q;
	logic [IDX_W-1:0]  best_slot_q;
	logic              best_act_q;
	logic              rd_act_q;
	logic [MAC_W-1:0]  rd_key_q;
	logic [RDG_W-1:0]  rd_rdg_q;
	logic [FLAG_W-1:0] rd_flag_q;

	logic              rsp_valid_q;
	stt_rsp_t          rsp_q;

	stt_cmp_t          verdict;
	logic              k_in_use;
	logic              k_is_idx;
	logic              can_emit;
	logic              finish;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_slot;
	logic [CNT_W-1:0]  next_count;
	stt_rsp_t          rsp_d;
	logic [CNT_W:0]    act_after;
	logic [RDG_W-1:0]  sight_rdg;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	stt_cmp u_cmp (
		.key      (key_s1),
		.stamp    (stamp_s1),
		.mac      (req_q.mac),
		.now_ms   (req_q.now_ms),
		.timeout  (timeout_q),
		.best_age (best_q),
		.verdict  (verdict)
	);

	assign k_in_use = (CNT_W'(pipe_k_s1) < count_q);
	assign k_is_idx = (INDEX_W'(pipe_k_s1) == req_q.index);
	assign can_emit = !rsp_valid_q || rsp_ready;
	assign finish   = (state_q == ST_DONE) && can_emit;

	assign sight_rdg = {req_q.frame_counter, req_q.batt_percent, req_q.batt_millivolts,
		req_q.humid_centi, req_q.temp_centi};

	// Final step: choose the slot, work out the new counts and build the beat.
	always_comb begin
		rsp_d            = '0;
		wr_en            = 1'b0;
		wr_slot          = hit_q;
		next_count       = count_q;
		act_after        = {1'b0, act_cnt_q};
		case (req_q.operation)
			OP_SIGHT: begin
				wr_en = 1'b1;
				if (found_q) begin
					wr_slot      = hit_q;
					rsp_d.action = ACT_UPDATED;
					act_after    = {1'b0, act_cnt_q} - (CNT_W+1)'(hit_act_q)
						+ (CNT_W+1)'(1);
				end else if (count_q < FULL_CNT) begin
					wr_slot      = count_q[IDX_W-1:0];
					next_count   = count_q + CNT_W'(1);
					rsp_d.action = ACT_APPENDED;
					act_after    = {1'b0, act_cnt_q} + (CNT_W+1)'(1);
				end else begin
					// Full and unknown: the entry with the greatest age goes.
					wr_slot      = best_slot_q;
					rsp_d.action = ACT_EVICTED;
					act_after    = {1'b0, act_cnt_q} - (CNT_W+1)'(best_act_q)
						+ (CNT_W+1)'(1);
				end
				rsp_d.slot = INDEX_W'(wr_slot);
			end
			OP_READ: begin
				rsp_d.slot = req_q.index;
				if ((COUNT_W)'(req_q.index) < COUNT_W'(count_q)) begin
					rsp_d.action         = ACT_READ_OK;
					rsp_d.entry_mac      = rd_key_q;
					rsp_d.entry_temp     = rd_rdg_q[15:0];
					rsp_d.entry_humid    = rd_rdg_q[31:16];
					rsp_d.entry_batt_mv  = rd_rdg_q[47:32];
					rsp_d.entry_batt_pct = rd_rdg_q[55:48];
					rsp_d.entry_counter  = rd_rdg_q[63:56];
					rsp_d.entry_flags    = rd_flag_q;
					rsp_d.entry_active   = rd_act_q;
				end else begin
					rsp_d.action = ACT_READ_OOR;
				end
			end
			OP_CLEAR: begin
				next_count   = '0;
				act_after    = '0;
				rsp_d.action = ACT_CLEARED;
			end
			default: begin
				rsp_d.action = ACT_CLEARED;
			end
		endcase
		rsp_d.tag_count    = COUNT_W'(next_count);
		rsp_d.active_count = COUNT_W'(act_after);
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			count_q     <= '0;
			timeout_q   <= TIMEOUT_RESET;
			pipe_vld_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			pipe_vld_s1 <= (state_q == ST_SCAN);
			// A new response takes the register in the same cycle as the
			// previous one leaves it.
			if (finish && (req_q.operation != OP_NONE)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						ptr_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (ptr_q == LAST_PTR) begin
						state_q <= ST_DRAIN;
					end else begin
						ptr_q <= ptr_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (req_q.operation == OP_NONE) begin
						state_q <= ST_IDLE;
					end else if (can_emit) begin
						count_q <= next_count;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture, scan bookkeeping and the response register.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q     <= req;
			found_q   <= 1'b0;
			act_cnt_q <= '0;
		end
		if (pipe_vld_s1) begin
			if (k_in_use && verdict.match) begin
				found_q   <= 1'b1;
				hit_q     <= pipe_k_s1;
				hit_act_q <= verdict.active;
			end
			if (k_in_use && verdict.active) begin
				act_cnt_q <= act_cnt_q + CNT_W'(1);
			end
			// Strictly greater keeps the lowest slot on a tie.
			if ((pipe_k_s1 == '0) || verdict.older) begin
				best_q      <= verdict.age;
				best_slot_q <= pipe_k_s1;
				best_act_q  <= verdict.active;
			end
			if (k_is_idx) begin
				rd_key_q  <= key_s1;
				rd_rdg_q  <= rdg_s1;
				rd_flag_q <= flag_s1;
				rd_act_q  <= verdict.active;
			end
		end
		if (finish) begin
			rsp_q <= rsp_d;
		end
	end

	// Entry store: one read row per scan cycle, one write in the final step.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			pipe_k_s1 <= ptr_q;
			key_s1    <= key_mem[ptr_q];
			rdg_s1    <= rdg_mem[ptr_q];
			flag_s1   <= flag_mem[ptr_q];
			stamp_s1  <= stamp_mem[ptr_q];
		end
		if (finish && wr_en) begin
			key_mem[wr_slot]   <= req_q.mac;
			rdg_mem[wr_slot]   <= sight_rdg;
			flag_mem[wr_slot]  <= req_q.tag_flags;
			stamp_mem[wr_slot] <= req_q.now_ms;
		end
	end

`ifndef SYNTHESIS
	// The table never claims more tags than it has room for.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL_CNT)
		else $error("tag count beyond table depth");

	// Active tags are a subset of the tags held.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.active_count <= rsp.tag_count))
		else $error("active count exceeds tag count");

	// An accepted request takes the block out of idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while a scan is under way");

	// A response is only raised by the final step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> ($past(state_q) == ST_DONE))
		else $error("response raised outside the final step");
`endif

endmodule
